FILE: hw/rtl/hmfd_pkg.sv
// ----------------------------------------------------------------------------
// hmfd_pkg
// Shared types, constants and helpers of the height map flow direction block.
// ----------------------------------------------------------------------------
package hmfd_pkg;

	// Default map size and fixed field widths
	localparam int DEF_MAX_COLS = 128;
	localparam int DEF_MAX_ROWS = 128;
	localparam int HEIGHT_BITS  = 16;
	localparam int COORD_W      = 7;
	localparam int POS_W        = 8;
	localparam int SIZE_W       = 8;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;
	localparam int STEP_W       = 4;

	// Input opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// Register indexes (word address bits of paddr)
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_COLS_IN_USE    = 2'd0;
	localparam reg_idx_t REG_ROWS_IN_USE    = 2'd1;
	localparam reg_idx_t REG_HEIGHT_CEILING = 2'd2;

	// Register reset values
	localparam logic [SIZE_W-1:0]             COLS_RESET    = 8'd128;
	localparam logic [SIZE_W-1:0]             ROWS_RESET    = 8'd128;
	localparam logic signed [HEIGHT_BITS-1:0] CEILING_RESET = 16'sh7FFF;

	// Window scan order: centre first, then the neighbours row by row
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_CENTER = 4'd0;
	localparam step_t STEP_NW     = 4'd1;
	localparam step_t STEP_SE     = 4'd8;

	typedef struct packed {
		logic                       opcode;
		logic [COORD_W-1:0]         cell_col;
		logic [COORD_W-1:0]         cell_row;
		logic signed [HEIGHT_BITS-1:0] cell_height;
	} req_item_t;

	typedef struct packed {
		logic [COORD_W-1:0]         flow_col;
		logic [COORD_W-1:0]         flow_row;
		logic signed [HEIGHT_BITS-1:0] lowest_height;
	} rsp_item_t;

	// One window read on its way to the accumulator
	typedef struct packed {
		logic             valid;
		step_t            step;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} probe_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	// Column offset of a scan step
	function automatic logic signed [1:0] step_dc(input step_t step);
		logic signed [1:0] dc;
		unique case (step)
			4'd1, 4'd4, 4'd6: dc = -2'sd1;
			4'd3, 4'd5, 4'd8: dc = 2'sd1;
			default:          dc = 2'sd0;
		endcase
		return dc;
	endfunction

	// Row offset of a scan step
	function automatic logic signed [1:0] step_dr(input step_t step);
		logic signed [1:0] dr;
		unique case (step)
			4'd1, 4'd2, 4'd3: dr = -2'sd1;
			4'd6, 4'd7, 4'd8: dr = 2'sd1;
			default:          dr = 2'sd0;
		endcase
		return dr;
	endfunction

endpackage

FILE: hw/rtl/hmfd_acc.sv
// ----------------------------------------------------------------------------
// hmfd_acc
// Folds the window heights read from the store into the flow target and the
// window minimum, one height per cycle.
// ----------------------------------------------------------------------------
module hmfd_acc
	import hmfd_pkg::*;
(
	input  logic                          clk,
	input  probe_t                        probe,
	input  logic signed [HEIGHT_BITS-1:0] rd_data,
	input  logic signed [HEIGHT_BITS-1:0] ceiling,
	output rsp_item_t                     result
);

	logic signed [HEIGHT_BITS-1:0] own_q;
	logic signed [HEIGHT_BITS-1:0] best_q;
	logic signed [HEIGHT_BITS-1:0] low_q;
	logic [POS_W-1:0]              best_col_q;
	logic [POS_W-1:0]              best_row_q;
	logic [POS_W-1:0]              lvl_col_q;
	logic [POS_W-1:0]              lvl_row_q;

	// Update the running best, level target and minimum
	always_ff @(posedge clk) begin
		if (probe.valid) begin
			if (probe.step == STEP_CENTER) begin
				own_q      <= rd_data;
				best_q     <= rd_data;
				best_col_q <= probe.col;
				best_row_q <= probe.row;
				lvl_col_q  <= probe.col;
				lvl_row_q  <= probe.row;
				low_q      <= (rd_data < ceiling) ? rd_data : ceiling;
			end else begin
				if (rd_data < best_q) begin
					best_q     <= rd_data;
					best_col_q <= probe.col;
					best_row_q <= probe.row;
				end else if (probe.step == STEP_SE && best_q == own_q && rd_data == own_q) begin
					lvl_col_q <= probe.col;
					lvl_row_q <= probe.row;
				end
				// The north-west corner stays out of the minimum
				if (probe.step != STEP_NW && rd_data < low_q) begin
					low_q <= rd_data;
				end
			end
		end
	end

	// Pick the lower neighbour, else the level target
	always_comb begin
		if (best_q < own_q) begin
			result.flow_col = best_col_q[COORD_W-1:0];
			result.flow_row = best_row_q[COORD_W-1:0];
		end else begin
			result.flow_col = lvl_col_q[COORD_W-1:0];
			result.flow_row = lvl_row_q[COORD_W-1:0];
		end
		result.lowest_height = low_q;
	end

endmodule

FILE: hw/rtl/heightmap_flow_direction.sv
// ----------------------------------------------------------------------------
// heightmap_flow_direction
// Height map store with D8 lowest-neighbour flow direction lookup.
// ----------------------------------------------------------------------------
// Usage:
// - Request channel (req_valid, req_stall, req): a write item (opcode write)
//   stores one height and gives no result. An evaluate item gives one
//   response on rsp_valid/rsp_stall/rsp with the flow target and the lowest
//   height of the window.
// - Items whose cell lies outside cols_in_use/rows_in_use (bounded by
//   MAX_COLS/MAX_ROWS) are dropped with no response.
// - An evaluation reads the in-map cells of its nine-cell window from the
//   single-port height store, one per cycle; the request channel stalls
//   until the result is loaded into the response register. Writes run at
//   one per cycle while idle. ST_DONE loads the response register.
// - The response register decouples the sides: writes are taken while a
//   response waits. A stalled response holds; a finished evaluation waits for
//   the response register to free up.
// - Reset clears the registers to their defaults and the control state. The
//   height store is not cleared; cells must be written before evaluation.
// - The user writes registers through the APB port while the block is idle; the block leaves it unchecked.
// ----------------------------------------------------------------------------
module heightmap_flow_direction
	import hmfd_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// Request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  req_item_t          req,
	// Response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_item_t          rsp
);

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [SIZE_W-1:0]             cols_q;
	logic [SIZE_W-1:0]             rows_q;
	logic signed [HEIGHT_BITS-1:0] ceiling_q;

	state_t state_q, state_d;
	step_t  step_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;

	logic req_fire, cell_in, wr_en, rd_en, start_eval, scan_en, load_rsp, cfg_wr;
	step_t cur_step;
	logic [COORD_W-1:0] base_col, base_row;
	logic signed [POS_W:0] nc, nr;
	logic [ADDR_W-1:0] addr;

	logic signed [HEIGHT_BITS-1:0] mem [DEPTH];
	logic signed [HEIGHT_BITS-1:0] rd_data_s1;
	probe_t probe_s1;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;
	rsp_item_t result;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= COLS_RESET;
			rows_q    <= ROWS_RESET;
			ceiling_q <= CEILING_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_COLS_IN_USE:    cols_q    <= pwdata[SIZE_W-1:0];
				REG_ROWS_IN_USE:    rows_q    <= pwdata[SIZE_W-1:0];
				REG_HEIGHT_CEILING: ceiling_q <= pwdata[HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_COLS_IN_USE:    prdata = PDATA_W'(cols_q);
			REG_ROWS_IN_USE:    prdata = PDATA_W'(rows_q);
			REG_HEIGHT_CEILING: prdata = PDATA_W'($unsigned(ceiling_q));
			default:            prdata = '0;
		endcase
	end

	// Cell coordinates of the current access and their bounds check
	always_comb begin
		cur_step = (state_q == ST_IDLE) ? STEP_CENTER : step_q;
		base_col = (state_q == ST_IDLE) ? req.cell_col : col_q;
		base_row = (state_q == ST_IDLE) ? req.cell_row : row_q;
		nc = $signed({2'b00, base_col}) + (POS_W+1)'(step_dc(cur_step));
		nr = $signed({2'b00, base_row}) + (POS_W+1)'(step_dr(cur_step));
		cell_in = !nc[POS_W] && !nr[POS_W]
			&& (nc[POS_W-1:0] < cols_q) && (nr[POS_W-1:0] < rows_q)
			&& (32'(nc[POS_W-1:0]) < 32'(MAX_COLS))
			&& (32'(nr[POS_W-1:0]) < 32'(MAX_ROWS));
		addr = ADDR_W'(32'(nr[POS_W-1:0]) * 32'(MAX_COLS) + 32'(nc[POS_W-1:0]));
	end

	assign req_fire   = req_valid && !req_stall;
	assign wr_en      = req_fire && req.opcode == OP_WRITE && cell_in;
	assign start_eval = req_fire && req.opcode == OP_EVAL && cell_in;
	assign rd_en      = start_eval || (scan_en && cell_in);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start_eval) state_d = ST_SCAN;
			ST_SCAN: if (step_q == STEP_SE) state_d = ST_LAST;
			ST_LAST: state_d = ST_DONE;
			ST_DONE: if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		req_stall = 1'b1;
		scan_en   = 1'b0;
		load_rsp  = 1'b0;
		unique case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_SCAN: scan_en   = 1'b1;
			ST_LAST: ;
			ST_DONE: load_rsp  = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_CENTER;
		end else begin
			state_q <= state_d;
			if (start_eval) begin
				step_q <= STEP_NW;
			end else if (scan_en) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Latch the evaluated cell
	always_ff @(posedge clk) begin
		if (start_eval) begin
			col_q <= req.cell_col;
			row_q <= req.cell_row;
		end
	end

	// Height store: one access per cycle, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= req.cell_height;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

	// Track each read alongside its data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_s1 <= '0;
		end else begin
			probe_s1.valid <= rd_en;
			probe_s1.step  <= cur_step;
			probe_s1.col   <= nc[POS_W-1:0];
			probe_s1.row   <= nr[POS_W-1:0];
		end
	end

	hmfd_acc u_acc (
		.clk     (clk),
		.probe   (probe_s1),
		.rd_data (rd_data_s1),
		.ceiling (ceiling_q),
		.result  (result)
	);

	// Response register: load on finish, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: bench/heightmap_flow_direction_tb.sv
// ----------------------------------------------------------------------------
// heightmap_flow_direction_tb
// Self-checking bench for the height map flow direction block. A short table
// of directed writes and evaluations runs first. Random write/evaluate
// sequences follow under several map sizes and ceilings. Every response is
// compared against a table entry or a behavioral D8 model kept in the bench.
// ----------------------------------------------------------------------------
module heightmap_flow_direction_tb;
	import hmfd_pkg::*;

	localparam int MAP_CELLS     = DEF_MAX_COLS * DEF_MAX_ROWS;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;

	// One row of the directed table
	typedef struct packed {
		req_item_t item;
		logic      typed;
		rsp_item_t want;
	} dir_step_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid;
	logic               req_stall;
	req_item_t          req;
	logic               rsp_valid;
	logic               rsp_stall;
	rsp_item_t          rsp;

	// Bench copy of the registers and of the height store
	logic [SIZE_W-1:0]             cfg_cols;
	logic [SIZE_W-1:0]             cfg_rows;
	logic signed [HEIGHT_BITS-1:0] cfg_ceiling;
	logic signed [HEIGHT_BITS-1:0] height_map [MAP_CELLS];
	// Cells written so far, tracked at generation time
	bit                            cell_set [MAP_CELLS];

	rsp_item_t flow_expected [$];
	dir_step_t dir_table [25];

	bit        cur_typed;
	rsp_item_t cur_want;
	int        errors;
	int        counted;
	int        quiet_cycles;
	int        send_idle_pct;
	int        recv_stall_pct;
	bit        hold_req;
	int        hold_left;

	heightmap_flow_direction u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int eff_cols();
		return (int'(cfg_cols) < DEF_MAX_COLS) ? int'(cfg_cols) : DEF_MAX_COLS;
	endfunction

	function automatic int eff_rows();
		return (int'(cfg_rows) < DEF_MAX_ROWS) ? int'(cfg_rows) : DEF_MAX_ROWS;
	endfunction

	function automatic bit in_map(input int c, input int r);
		return c >= 0 && r >= 0 && c < eff_cols() && r < eff_rows();
	endfunction

	function automatic int cell_index(input int c, input int r);
		return r * DEF_MAX_COLS + c;
	endfunction

	// Apply one accepted item to the store; return 1 with the flow result for
	// an in-map evaluation
	function automatic bit predict_flow(input req_item_t item, output rsp_item_t res);
		int col, row, nc, nr, dr, dc, best_c, best_r, lvl_c, lvl_r;
		logic signed [HEIGHT_BITS-1:0] here, best, floor_h, h;
		col = item.cell_col;
		row = item.cell_row;
		res = '0;
		if (!in_map(col, row))
			return 1'b0;
		if (item.opcode == OP_WRITE) begin
			height_map[cell_index(col, row)] = item.cell_height;
			return 1'b0;
		end
		here   = height_map[cell_index(col, row)];
		best   = here;
		best_c = col;
		best_r = row;
		lvl_c  = col;
		lvl_r  = row;
		// Scan neighbors row by row; strictly lower wins, first kept on ties
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				nc = col + dc;
				nr = row + dr;
				if ((dc != 0 || dr != 0) && in_map(nc, nr)) begin
					h = height_map[cell_index(nc, nr)];
					if (h < best) begin
						best   = h;
						best_c = nc;
						best_r = nr;
					end else if (dc == 1 && dr == 1 && best == here && h == here) begin
						lvl_c = nc;
						lvl_r = nr;
					end
				end
			end
		end
		// No descent: fall back to a level south-east neighbor or the cell
		if (!(best < here)) begin
			best_c = lvl_c;
			best_r = lvl_r;
		end
		// Window minimum without the north-west corner
		floor_h = cfg_ceiling;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = (dr == -1) ? 0 : -1; dc <= 1; dc++) begin
				nc = col + dc;
				nr = row + dr;
				if (in_map(nc, nr)) begin
					h = height_map[cell_index(nc, nr)];
					if (h < floor_h)
						floor_h = h;
				end
			end
		end
		res.flow_col      = COORD_W'(best_c);
		res.flow_row      = COORD_W'(best_r);
		res.lowest_height = floor_h;
		return 1'b1;
	endfunction

	function automatic dir_step_t dir_write(input int c, input int r, input int h);
		dir_step_t s;
		s                  = '0;
		s.item.opcode      = OP_WRITE;
		s.item.cell_col    = COORD_W'(c);
		s.item.cell_row    = COORD_W'(r);
		s.item.cell_height = HEIGHT_BITS'(h);
		return s;
	endfunction

	function automatic dir_step_t dir_eval(input int c, input int r, input bit typed,
			input int fc, input int fr, input int lo);
		dir_step_t s;
		s                    = '0;
		s.item.opcode        = OP_EVAL;
		s.item.cell_col      = COORD_W'(c);
		s.item.cell_row      = COORD_W'(r);
		s.item.cell_height   = HEIGHT_BITS'($urandom);
		s.typed              = typed;
		s.want.flow_col      = COORD_W'(fc);
		s.want.flow_row      = COORD_W'(fr);
		s.want.lowest_height = HEIGHT_BITS'(lo);
		return s;
	endfunction

	// Often small or extreme heights so that ties and level cells come up often
	function automatic logic signed [HEIGHT_BITS-1:0] rand_height();
		logic signed [HEIGHT_BITS-1:0] h;
		case ($urandom_range(9))
			0:          h = 16'sh8000;
			1:          h = 16'sh7FFF;
			2, 3, 4, 5: h = HEIGHT_BITS'(int'($urandom_range(4)) - 2);
			default:    h = HEIGHT_BITS'($urandom);
		endcase
		return h;
	endfunction

	// Favor the map edges and one inner patch so the written area stays small
	function automatic int pick_coord(input int lim);
		int v;
		case ($urandom_range(3))
			0:       v = $urandom_range(3);
			1:       v = lim - 1 - int'($urandom_range(3));
			2:       v = 40 + int'($urandom_range(7));
			default: v = $urandom_range(lim - 1);
		endcase
		return v % lim;
	endfunction

	// Offer one item after a random gap and hold it until the transfer
	task automatic send_cell(input logic op, input int col, input int row,
			input logic signed [HEIGHT_BITS-1:0] h, input bit typed, input rsp_item_t want);
		req_item_t item;
		item.opcode      = op;
		item.cell_col    = COORD_W'(col);
		item.cell_row    = COORD_W'(row);
		item.cell_height = h;
		if (in_map(col, row)) begin
			counted++;
			if (op == OP_WRITE)
				cell_set[cell_index(col, row)] = 1'b1;
		end
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		cur_typed = typed;
		cur_want  = want;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Fill the window of a cell, reshuffle some heights, then evaluate it
	task automatic flow_sequence();
		int col, row, nc, nr, dr, dc;
		col = pick_coord(eff_cols());
		row = pick_coord(eff_rows());
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				nc = col + dc;
				nr = row + dr;
				if (in_map(nc, nr) && (!cell_set[cell_index(nc, nr)] || $urandom_range(3) == 0))
					send_cell(OP_WRITE, nc, nr, rand_height(), 1'b0, '0);
			end
		end
		send_cell(OP_EVAL, col, row, HEIGHT_BITS'($urandom), 1'b0, '0);
	endtask

	// Out-of-map item of either kind, or a plain write when the item falls inside the map
	task automatic noise_item();
		int col, row;
		logic op;
		col = $urandom_range(DEF_MAX_COLS - 1);
		row = $urandom_range(DEF_MAX_ROWS - 1);
		op  = 1'($urandom_range(1));
		if (eff_cols() < DEF_MAX_COLS && $urandom_range(1))
			col = eff_cols() + int'($urandom_range(DEF_MAX_COLS - 1 - eff_cols()));
		else if (eff_rows() < DEF_MAX_ROWS)
			row = eff_rows() + int'($urandom_range(DEF_MAX_ROWS - 1 - eff_rows()));
		if (in_map(col, row))
			op = OP_WRITE;
		send_cell(op, col, row, rand_height(), 1'b0, '0);
	endtask

	task automatic run_phase(input int quota);
		counted = 0;
		while (counted < quota) begin
			if ($urandom_range(7) == 0)
				noise_item();
			else
				flow_sequence();
		end
	endtask

	// Drop valid, wait for every response, then let the block settle
	task automatic finish_phase();
		@(negedge clk);
		req_valid <= 1'b0;
		while (flow_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write followed by a read back of the same register
	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value,
			input int width);
		logic [PDATA_W-1:0] mask;
		mask = (32'h1 << width) - 32'h1;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_COLS_IN_USE:    cfg_cols    = value[SIZE_W-1:0];
			REG_ROWS_IN_USE:    cfg_rows    = value[SIZE_W-1:0];
			REG_HEIGHT_CEILING: cfg_ceiling = value[HEIGHT_BITS-1:0];
			default:            ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (value & mask)) begin
			$display("%0t: register %0d read back: expected %0h, actual %0h",
				$time, idx, value & mask, prdata & mask);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int cols, input int rows, input int ceiling);
		write_reg(REG_COLS_IN_USE, PDATA_W'(cols), SIZE_W);
		write_reg(REG_ROWS_IN_USE, PDATA_W'(rows), SIZE_W);
		write_reg(REG_HEIGHT_CEILING, PDATA_W'(ceiling), HEIGHT_BITS);
	endtask

	// Receiver: random stall, or one long hold-off when asked
	initial begin
		rsp_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Check responses against the oldest expectation, predict on each request
	always @(posedge clk) begin : monitor
		rsp_item_t predicted;
		rsp_item_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (flow_expected.size() == 0) begin
					$display("%0t: unexpected response: expected none, actual col %0d row %0d low %0d",
						$time, rsp.flow_col, rsp.flow_row, rsp.lowest_height);
					errors++;
				end else begin
					want = flow_expected.pop_front();
					if (rsp.flow_col !== want.flow_col || rsp.flow_row !== want.flow_row ||
							rsp.lowest_height !== want.lowest_height) begin
						$display("%0t: flow mismatch: expected col %0d row %0d low %0d, actual col %0d row %0d low %0d",
							$time, want.flow_col, want.flow_row, want.lowest_height,
							rsp.flow_col, rsp.flow_row, rsp.lowest_height);
						errors++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (predict_flow(req, predicted))
					flow_expected.insert(flow_expected.size(), cur_typed ? cur_want : predicted);
			end
		end
		// Count cycles with no transfer on either channel
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("heightmap_flow_direction regression: fail");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_valid      = 1'b0;
		req            = '0;
		errors         = 0;
		counted        = 0;
		quiet_cycles   = 0;
		hold_req       = 1'b0;
		cur_typed      = 1'b0;
		cur_want       = '0;
		cfg_cols       = COLS_RESET;
		cfg_rows       = ROWS_RESET;
		cfg_ceiling    = CEILING_RESET;
		send_idle_pct  = 18;
		recv_stall_pct = 70;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset sizes and ceiling
		dir_table = '{
			dir_write(0, 0, 7), dir_write(1, 0, 7), dir_write(0, 1, 9), dir_write(1, 1, 7),
			// level south-east neighbor takes the flow
			dir_eval(0, 0, 1'b1, 1, 1, 7),
			dir_write(0, 0, -32768),
			// pit: flow stays on the cell
			dir_eval(0, 0, 1'b1, 0, 0, -32768),
			dir_write(127, 127, 100), dir_write(126, 127, 100),
			dir_write(127, 126, 100), dir_write(126, 126, -32768),
			// descent into the corner that the minimum leaves out
			dir_eval(127, 127, 1'b1, 126, 126, 100),
			dir_write(2, 0, 3), dir_write(2, 1, 3), dir_write(0, 2, 5),
			dir_write(1, 2, 3), dir_write(2, 2, 7),
			dir_eval(1, 1, 1'b0, 0, 0, 0),
			dir_write(0, 0, 32767),
			// tie among lower neighbors
			dir_eval(1, 1, 1'b0, 0, 0, 0),
			dir_write(127, 127, 32767), dir_write(126, 127, 32767),
			dir_write(127, 126, 32767), dir_write(126, 126, 32767),
			// flat top at the far corner
			dir_eval(127, 127, 1'b1, 127, 127, 32767)
		};
		foreach (dir_table[i])
			send_cell(dir_table[i].item.opcode, dir_table[i].item.cell_col,
				dir_table[i].item.cell_row, dir_table[i].item.cell_height,
				dir_table[i].typed, dir_table[i].want);
		finish_phase();

		// Busy sender, slow receiver; start with a long receiver hold-off
		set_config(128, 128, 32767);
		hold_req = 1'b1;
		run_phase(450);
		finish_phase();
		set_config(4, 4, 0);
		run_phase(300);
		finish_phase();

		// Slow sender, quick receiver
		send_idle_pct  = 70;
		recv_stall_pct = 18;
		set_config(255, 200, -32768);
		run_phase(350);
		finish_phase();
		// Zero sizes drop every item
		set_config(0, 128, 32767);
		repeat (12) noise_item();
		finish_phase();
		set_config(128, 0, 32767);
		repeat (12) noise_item();
		finish_phase();
		// Pause the sender midway until all responses are back
		set_config(37, 128, -5);
		run_phase(150);
		finish_phase();
		run_phase(150);
		finish_phase();

		// No idling on either side
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_config(128, 4, 32767);
		run_phase(250);
		finish_phase();
		set_config(100, 77, int'($urandom_range(65535)) - 32768);
		run_phase(200);
		finish_phase();

		if (errors == 0)
			$display("heightmap_flow_direction regression: pass");
		else
			$display("heightmap_flow_direction regression: fail");
		$finish;
	end

endmodule
